@@ src/cofactor_determinant_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the cofactor determinant block
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COFACTOR_DETERMINANT_MACROS_SVH
`define COFACTOR_DETERMINANT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a condition at every clock edge.
`define CFD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cofactor_determinant assertion failed");
// Check that an antecedent implies a consequent at the same edge.
`define CFD_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cofactor_determinant assertion failed");
`else
`define CFD_ASSERT(lbl, cond)
`define CFD_IMPLY(lbl, ante, cons)
`endif

`endif

@@ src/cfd_pkg.sv @@
// ---------------------------------------------------------------------------
// cfd_pkg
// Types, sizes and the permutation table of the determinant block.
// ---------------------------------------------------------------------------
package cfd_pkg;

  localparam int MAX_N     = 4;
  localparam int ELEM_BITS = 16;
  localparam int IDX_W     = 2;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int N_W       = 3;
  localparam int PROD_W    = ELEM_BITS * MAX_N;
  localparam int MUL_A_W   = ELEM_BITS * (MAX_N - 1);
  localparam int ACC_W     = PROD_W + 8;
  localparam int DET_W     = 64;
  localparam int NUM_PERM  = 24;
  localparam int PERM_W    = 5;

  localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

  typedef struct packed {
    logic [IDX_W-1:0]            elem_row;
    logic [IDX_W-1:0]            elem_col;
    logic signed [ELEM_BITS-1:0] elem_value;
    logic                        last;
  } in_data_t;

  typedef struct packed {
    logic signed [DET_W-1:0] determinant;
    logic                    overflow;
  } out_data_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [ELEM_BITS-1:0] data;
  } wr_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } seq_state_t;

  // {odd sign, p3, p2, p1, p0}: column used by each row, lexicographic order
  function automatic logic [8:0] perm_entry(input logic [PERM_W-1:0] idx);
    logic [8:0] e;
    unique case (idx)
      5'd0:  e = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
      5'd1:  e = {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
      5'd2:  e = {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
      5'd3:  e = {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
      5'd4:  e = {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
      5'd5:  e = {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
      5'd6:  e = {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
      5'd7:  e = {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
      5'd8:  e = {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
      5'd9:  e = {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
      5'd10: e = {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
      5'd11: e = {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
      5'd12: e = {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
      5'd13: e = {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
      5'd14: e = {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
      5'd15: e = {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
      5'd16: e = {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
      5'd17: e = {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
      5'd18: e = {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
      5'd19: e = {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
      5'd20: e = {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
      5'd21: e = {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
      5'd22: e = {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
      5'd23: e = {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
      default: e = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
    endcase
    return e;
  endfunction

endpackage

@@ src/cfd_store.sv @@
// ---------------------------------------------------------------------------
// cfd_store
// Matrix entry memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module cfd_store
  import cfd_pkg::*;
(
  input  logic                 clk,
  input  wr_req_t              wr,
  input  rd_req_t              rd,
  output logic [ELEM_BITS-1:0] rd_data
);

  logic [ELEM_BITS-1:0] mem [MAX_N*MAX_N];
  logic [ELEM_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/cfd_seq.sv @@
// ---------------------------------------------------------------------------
// cfd_seq
// Walks the permutation table, multiplies the selected entries read from
// the store and accumulates the signed terms; saturates the final sum.
// ---------------------------------------------------------------------------
module cfd_seq
  import cfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [N_W-1:0]       size_n,
  input  logic                 out_free,
  input  logic [ELEM_BITS-1:0] rd_data,
  output rd_req_t              rd,
  output logic                 idle,
  output logic                 done,
  output out_data_t            result
);

  seq_state_t state_r, state_nxt;
  logic [PERM_W-1:0] perm_r, perm_nxt;
  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [N_W-1:0]    n_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  logic [8:0]       pe;
  logic             qual;
  logic             last_row;
  logic             last_perm;
  logic [IDX_W-1:0] col_sel;
  logic [IDX_W-1:0] rd_row;
  logic signed [ACC_W-1:0] term;
  logic acc_fits;

  assign pe        = perm_entry(perm_r);
  assign last_perm = (perm_r == PERM_W'(NUM_PERM - 1));
  assign last_row  = ({1'b0, row_r} == n_r - N_W'(1));

  // a permutation counts only if it fixes every row at or above the size
  always_comb begin
    qual = 1'b1;
    for (int i = 0; i < MAX_N; i++) begin
      if ((N_W'(i) >= n_r) && (pe[2*i +: IDX_W] != IDX_W'(i))) begin
        qual = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (qual) state_nxt = ST_MUL;
        else if (last_perm) state_nxt = ST_FIN;
      end
      ST_MUL:   if (last_row) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last_perm ? ST_FIN : ST_CHECK;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_row = row_r + IDX_W'(1);
    rd.en  = 1'b0;
    idle   = 1'b0;
    done   = 1'b0;
    unique case (state_r)
      ST_IDLE:  idle = 1'b1;
      ST_CHECK: begin
        rd_row = '0;
        rd.en  = qual;
      end
      ST_MUL:   rd.en = !last_row;
      ST_FIN:   done = out_free;
      default:  ;
    endcase
    col_sel = pe[2*rd_row +: IDX_W];
    rd.addr = {rd_row, col_sel};
  end

  assign term = ACC_W'(prod_r);

  always_comb begin
    perm_nxt = perm_r;
    row_nxt  = row_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        perm_nxt = '0;
        acc_nxt  = '0;
      end
      ST_CHECK: begin
        row_nxt = '0;
        if (!qual && !last_perm) perm_nxt = perm_r + PERM_W'(1);
      end
      ST_MUL: begin
        // first row loads, later rows multiply the running product
        if (row_r == '0) begin
          prod_nxt = PROD_W'(signed'(rd_data));
        end else begin
          prod_nxt = PROD_W'(signed'(prod_r[MUL_A_W-1:0]) * signed'(rd_data));
        end
        row_nxt = row_r + IDX_W'(1);
      end
      ST_ACC: begin
        acc_nxt = pe[8] ? (acc_r - term) : (acc_r + term);
        if (!last_perm) perm_nxt = perm_r + PERM_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    perm_r <= perm_nxt;
    row_r  <= row_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (start && state_r == ST_IDLE) begin
      n_r <= size_n;
    end
  end

  assign acc_fits = (acc_r[ACC_W-1:DET_W-1] == '0) || (acc_r[ACC_W-1:DET_W-1] == '1);

  always_comb begin
    result.overflow = !acc_fits;
    if (acc_fits) begin
      result.determinant = acc_r[DET_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      result.determinant = {1'b1, {(DET_W-1){1'b0}}};
    end else begin
      result.determinant = {1'b0, {(DET_W-1){1'b1}}};
    end
  end

endmodule

@@ src/cofactor_determinant.sv @@
// Operation: an item without last is stored in memory; a last item starts the
// sequencer, which checks all 24 permutations and, for each one that fits the
// size, does one memory read and multiply per row and one accumulate; out_valid
// rises from the FIN state once the output register is free.
// Throughput: one request per cycle while idle; one determinant at a time.
// Reset: synchronous, active low; matrix_size returns to 4, memory is unset.
// ---------------------------------------------------------------------------
// cofactor_determinant
// Loads a matrix into memory and returns its determinant, saturated to 64 bits.
// ---------------------------------------------------------------------------
`include "cofactor_determinant_macros.svh"

module cofactor_determinant
  import cfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  in_data_t     in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output out_data_t    out_data,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [N_W-1:0] size_r;
  logic [N_W-1:0] eff_n;
  logic           in_acc;
  logic           seq_idle;
  logic           seq_done;
  logic           out_free;
  logic           out_valid_r;
  out_data_t      out_data_r;
  out_data_t      seq_result;
  wr_req_t        wr;
  rd_req_t        rd;
  logic [ELEM_BITS-1:0] rd_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MATRIX_SIZE) ? 32'(size_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= N_W'(MAX_N);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_MATRIX_SIZE) begin
      size_r <= cfg_pwdata[N_W-1:0];
    end
  end

  always_comb begin
    if (size_r == '0) eff_n = N_W'(1);
    else if (size_r > N_W'(MAX_N)) eff_n = N_W'(MAX_N);
    else eff_n = size_r;
  end

  assign in_stall = !seq_idle;
  assign in_acc   = in_valid && !in_stall;

  assign wr.en   = in_acc;
  assign wr.addr = {in_data.elem_row, in_data.elem_col};
  assign wr.data = in_data.elem_value;

  cfd_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;

  cfd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && in_data.last),
    .size_n   (eff_n),
    .out_free (out_free),
    .rd_data  (rd_data),
    .rd       (rd),
    .idle     (seq_idle),
    .done     (seq_done),
    .result   (seq_result)
  );

  // hold the result until the request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_data_r <= seq_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CFD_IMPLY(a_done_has_room, seq_done, out_free)
  `CFD_IMPLY(a_load_only_idle, in_acc, seq_idle)
  `CFD_IMPLY(a_result_from_seq, $rose(out_valid_r), $past(seq_done))
  `CFD_ASSERT(a_no_read_idle, !(seq_idle && rd.en))

endmodule
